// ===== design/frkc_pkg.sv =====
// shared types and constants for the fifo replacement key cache
`default_nettype none

package frkc_pkg;

  localparam int KEY_W  = 32;
  localparam int SLOT_W = 4;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             fill_ok;
  } frkc_in_t;

  typedef struct packed {
    logic              hit;
    logic              handle_valid;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } frkc_out_t;

  // control bits that ride with a lookup as it walks the cells
  typedef struct packed {
    logic valid;
    logic hit;
    logic fill_ok;
  } frkc_flags_t;

endpackage

`default_nettype wire

// ===== design/frkc_cell.sv =====
// one slot of the key store: holds a key and compares it as a lookup walks past
`default_nettype none

module frkc_cell
  import frkc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KW          = 32,
  parameter int CELL_IDX    = 0
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire frkc_flags_t                          prev_flags,
  input  wire logic [KW-1:0]                        prev_key,
  input  wire logic [$clog2(MAX_ENTRIES)-1:0]       prev_slot,
  input  wire logic [KW-1:0]                        prev_ekey,
  input  wire logic [$clog2(MAX_ENTRIES)-1:0]       oldest,
  input  wire logic [$clog2(MAX_ENTRIES+1)-1:0]     count,
  input  wire logic                                 wr_en,
  input  wire logic [$clog2(MAX_ENTRIES)-1:0]       wr_slot,
  input  wire logic [KW-1:0]                        wr_key,
  output frkc_flags_t                               next_flags,
  output logic [KW-1:0]                             next_key,
  output logic [$clog2(MAX_ENTRIES)-1:0]            next_slot,
  output logic [KW-1:0]                             next_ekey
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [KW-1:0]    key_r;
  frkc_flags_t      flags_r;
  logic [KW-1:0]    tkey_r;
  logic [IDX_W-1:0] slot_r;
  logic [KW-1:0]    ekey_r;

  logic [IDX_W:0]   diff;
  logic [IDX_W:0]   offset;
  logic             live;
  logic             match;

  // distance from the oldest slot, wrapped around the ring
  always_comb begin
    diff = {1'b0, MY_IDX} - {1'b0, oldest};
    if (MY_IDX >= oldest) begin
      offset = diff;
    end else begin
      offset = diff + (IDX_W+1)'(MAX_ENTRIES);
    end
    live  = offset < (IDX_W+1)'(count);
    match = live && (key_r == prev_key);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r.valid   <= prev_flags.valid;
      flags_r.hit     <= prev_flags.hit | match;
      flags_r.fill_ok <= prev_flags.fill_ok;
    end
  end

  always_ff @(posedge clk) begin
    tkey_r <= prev_key;
    slot_r <= match ? MY_IDX : prev_slot;
    // pick up the key that would be dropped on an eviction
    ekey_r <= (MY_IDX == oldest) ? key_r : prev_ekey;
    if (wr_en && (wr_slot == MY_IDX)) begin
      key_r <= wr_key;
    end
  end

  assign next_flags = flags_r;
  assign next_key   = tkey_r;
  assign next_slot  = slot_r;
  assign next_ekey  = ekey_r;

endmodule

`default_nettype wire

// ===== design/fifo_replacement_key_cache_top.sv =====
// top level of the fifo replacement key cache: cell chain, ring pointers, result register
//
//   channel   ports                         beat taken when
//   input     start, busy, in_data          start && !busy
//   result    out_valid, out_data           out_valid (one cycle, no backpressure)
//   config    cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// a lookup walks the cell row one cell per cycle, then the result register,
// up to the out_valid strobe; busy is high for that whole span. the fill and
// pointer update land on the strobe edge, so the next start is taken the
// cycle after it. reset (synchronous, rst_n low) empties the ring and loads
// capacity 16; stored keys are not cleared.
`default_nettype none

module fifo_replacement_key_cache_top
  import frkc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int KEY_BITS    = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire frkc_in_t         in_data,
  output logic                  out_valid,
  output frkc_out_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data
);

  localparam int KW    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic             busy_r;
  logic             out_valid_r;
  frkc_out_t        out_data_r;
  frkc_out_t        out_data_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [IDX_W-1:0] oldest_r;
  logic [CNT_W-1:0] count_r;

  frkc_flags_t      link_flags [0:MAX_ENTRIES];
  logic [KW-1:0]    link_key   [0:MAX_ENTRIES];
  logic [IDX_W-1:0] link_slot  [0:MAX_ENTRIES];
  logic [KW-1:0]    link_ekey  [0:MAX_ENTRIES];

  logic             accept;
  logic             done;
  logic             fill;
  logic             evict;
  logic [CNT_W:0]   ring_sum;
  logic [IDX_W-1:0] new_slot;
  logic [CW-1:0]    cap_ext;
  logic [CW-1:0]    eff_cap;
  frkc_flags_t      last_flags;

  assign accept = start && !busy_r;

  assign link_flags[0] = '{valid: accept, hit: 1'b0, fill_ok: in_data.fill_ok};
  assign link_key[0]   = KW'(in_data.key);
  assign link_slot[0]  = '0;
  assign link_ekey[0]  = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    frkc_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KW          (KW),
      .CELL_IDX    (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .prev_flags (link_flags[i]),
      .prev_key   (link_key[i]),
      .prev_slot  (link_slot[i]),
      .prev_ekey  (link_ekey[i]),
      .oldest     (oldest_r),
      .count      (count_r),
      .wr_en      (fill),
      .wr_slot    (new_slot),
      .wr_key     (link_key[MAX_ENTRIES]),
      .next_flags (link_flags[i+1]),
      .next_key   (link_key[i+1]),
      .next_slot  (link_slot[i+1]),
      .next_ekey  (link_ekey[i+1])
    );
  end

  always_comb begin
    last_flags = link_flags[MAX_ENTRIES];
    done       = last_flags.valid;
    fill       = done && !last_flags.hit && last_flags.fill_ok;

    // slot after the newest entry
    ring_sum = (CNT_W+1)'(oldest_r) + (CNT_W+1)'(count_r);
    if (ring_sum >= (CNT_W+1)'(MAX_ENTRIES)) begin
      new_slot = IDX_W'(ring_sum - (CNT_W+1)'(MAX_ENTRIES));
    end else begin
      new_slot = IDX_W'(ring_sum);
    end

    // capacity held to 1..MAX_ENTRIES
    cap_ext = CW'(cap_r);
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(MAX_ENTRIES)) begin
      eff_cap = CW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    evict = (CW+1)'(count_r) + (CW+1)'(1) > (CW+1)'(eff_cap);

    out_data_nxt = '0;
    if (last_flags.hit) begin
      out_data_nxt.hit          = 1'b1;
      out_data_nxt.handle_valid = 1'b1;
      out_data_nxt.slot         = SLOT_W'(link_slot[MAX_ENTRIES]);
    end else if (last_flags.fill_ok) begin
      out_data_nxt.handle_valid = 1'b1;
      out_data_nxt.slot         = SLOT_W'(new_slot);
      if (evict) begin
        out_data_nxt.evicted     = 1'b1;
        out_data_nxt.evicted_key = KEY_W'(link_ekey[MAX_ENTRIES]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
      oldest_r    <= '0;
      count_r     <= '0;
    end else begin
      out_valid_r <= done;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (fill) begin
        if (evict) begin
          if (oldest_r == IDX_W'(MAX_ENTRIES - 1)) begin
            oldest_r <= '0;
          end else begin
            oldest_r <= oldest_r + IDX_W'(1);
          end
        end else begin
          count_r <= count_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for the fifo replacement key cache top level
module tb_top;
  import frkc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES        = 16;
  localparam int HOLD_OFF       = ENTRIES + 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int POOL_MAX       = 24;
  localparam int CHUNK_ITEMS    = 50;
  localparam int CHUNKS         = 6;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  frkc_in_t         in_data = '0;
  logic             out_valid;
  frkc_out_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  // shadow copy of the cache contents and the capacity register
  logic [KEY_W-1:0] cache_keys [ENTRIES];
  int               oldest_slot = 0;
  int               live_count = 0;
  int               capacity_reg = 16;

  frkc_out_t        expected_lookups [$];
  int               mismatch_count = 0;
  int               idle_cycles = 0;

  logic [KEY_W-1:0] key_pool [POOL_MAX];
  int               pool_n = POOL_MAX;

  fifo_replacement_key_cache_top #(
    .MAX_ENTRIES(ENTRIES),
    .KEY_BITS   (KEY_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // one lookup against the shadow cache, updating it as the block would
  function automatic frkc_out_t lookup_cache(input frkc_in_t item);
    frkc_out_t r;
    int        s;
    int        new_slot;
    int        limit;
    bit        found;
    r = '0;
    found = 1'b0;
    for (int i = 0; i < live_count && i < ENTRIES; i++) begin
      s = (oldest_slot + i) % ENTRIES;
      if (!found && cache_keys[s] == item.key) begin
        found = 1'b1;
        r.hit = 1'b1;
        r.handle_valid = 1'b1;
        r.slot = s[SLOT_W-1:0];
      end
    end
    if (!found && item.fill_ok) begin
      limit = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : capacity_reg;
      new_slot = (oldest_slot + live_count) % ENTRIES;
      r.handle_valid = 1'b1;
      r.slot = new_slot[SLOT_W-1:0];
      // old key is read before the new one lands, the slots can coincide
      if (live_count + 1 > limit) begin
        r.evicted = 1'b1;
        r.evicted_key = cache_keys[oldest_slot];
        oldest_slot = (oldest_slot + 1) % ENTRIES;
      end else begin
        live_count++;
      end
      cache_keys[new_slot] = item.key;
    end
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_lookup(input logic [KEY_W-1:0] key, input logic fill_ok);
    frkc_in_t item;
    item.key = key;
    item.fill_ok = fill_ok;
    start <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    expected_lookups.push_back(lookup_cache(item));
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    while (expected_lookups.size() != 0) @(negedge clk);
  endtask

  task automatic set_capacity(input int value);
    wait_for_drain();
    cfg_valid <= 1'b1;
    cfg_data <= value[CAP_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    capacity_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    frkc_out_t want;
    if (rst_n && out_valid) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_lookups[0];
        expected_lookups.delete(0);
        if (out_data.hit !== want.hit)
          report_mismatch($sformatf("hit %b, want %b", out_data.hit, want.hit));
        if (out_data.handle_valid !== want.handle_valid)
          report_mismatch($sformatf("handle_valid %b, want %b",
                                    out_data.handle_valid, want.handle_valid));
        if (out_data.slot !== want.slot)
          report_mismatch($sformatf("slot %0d, want %0d", out_data.slot, want.slot));
        if (out_data.evicted !== want.evicted)
          report_mismatch($sformatf("evicted %b, want %b", out_data.evicted, want.evicted));
        if (out_data.evicted_key !== want.evicted_key)
          report_mismatch($sformatf("evicted_key %h, want %h",
                                    out_data.evicted_key, want.evicted_key));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // capacity of one while the ring is nearly empty: each fill after the first replaces the last
  task automatic test_capacity_one();
    set_capacity(1);
    send_lookup(32'h1357_9BDF, 1'b1);
    send_lookup(32'h2468_ACE0, 1'b1);
    send_lookup(32'h2468_ACE0, 1'b0);
    send_lookup(32'h1357_9BDF, 1'b0);
  endtask

  task automatic test_capacity_three();
    set_capacity(3);
    send_lookup(32'h3000_000C, 1'b1);
    send_lookup(32'h3000_000D, 1'b1);
    send_lookup(32'h3000_000E, 1'b1);
    send_lookup(32'h3000_000C, 1'b1);
  endtask

  // all-zero and all-one keys, hits that ignore fill_ok, failed fills
  task automatic test_key_extremes();
    set_capacity(16);
    send_lookup(32'h0000_0000, 1'b0);
    send_lookup(32'h0000_0000, 1'b1);
    send_lookup(32'hFFFF_FFFF, 1'b1);
    send_lookup(32'h0000_0000, 1'b0);
    send_lookup(32'hFFFF_FFFF, 1'b0);
    send_lookup(32'h1234_5678, 1'b0);
  endtask

  // fill the whole ring, wrap once, then lower capacity under the count
  task automatic test_fill_to_overflow();
    for (int i = 0; i < 12; i++) send_lookup(32'h5A5A_0000 + i, 1'b1);
    send_lookup(32'h0000_0000, 1'b0);
    set_capacity(4);
    send_lookup(32'h6B6B_0001, 1'b1);
    send_lookup(32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_random_traffic(input int idle_pct);
    logic [KEY_W-1:0] key;
    int               cap;
    for (int c = 0; c < CHUNKS; c++) begin
      cap = (c == 0) ? 1 : (c == 1) ? 16 : $urandom_range(1, 16);
      set_capacity(cap);
      // refresh part of the key pool so old entries age out
      for (int k = 0; k < 6; k++) key_pool[$urandom_range(POOL_MAX - 1)] = $urandom;
      pool_n = $urandom_range(17, POOL_MAX);
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        // idle decided per cycle
        while ($urandom_range(99) < idle_pct) pause_sender(1);
        if ($urandom_range(9) < 8) key = key_pool[$urandom_range(pool_n - 1)];
        else key = $urandom;
        send_lookup(key, $urandom_range(9) != 0);
      end
    end
  endtask

  initial begin
    for (int k = 0; k < POOL_MAX; k++) key_pool[k] = $urandom;
    for (int k = 0; k < ENTRIES; k++) cache_keys[k] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_capacity_one();
    test_capacity_three();
    test_key_extremes();
    test_fill_to_overflow();
    test_random_traffic(11);
    test_random_traffic(47);
    test_random_traffic(0);

    wait_for_drain();
    repeat (HOLD_OFF) @(posedge clk);
    if (expected_lookups.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_lookups.size()));
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== fifo_replacement_key_cache_top.f =====
design/frkc_pkg.sv
design/frkc_cell.sv
design/fifo_replacement_key_cache_top.sv
sim/tb_top.sv
